// ===== sv/rvx_pkg.sv =====
// rvx_pkg: opcodes, function codes and result word layout for the rv64i execute core
`timescale 1ns / 1ps
package rvx_pkg;

  // major opcodes
  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_JAL    = 7'h6F;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_LUI    = 7'h37;

  // alu funct3
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  // branch funct3
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  // load funct3
  localparam logic [2:0] F3_LB  = 3'd0;
  localparam logic [2:0] F3_LH  = 3'd1;
  localparam logic [2:0] F3_LW  = 3'd2;
  localparam logic [2:0] F3_LD  = 3'd3;
  localparam logic [2:0] F3_LBU = 3'd4;
  localparam logic [2:0] F3_LHU = 3'd5;
  localparam logic [2:0] F3_LWU = 3'd6;
  localparam logic [2:0] F3_BAD = 3'd7;

  localparam logic [2:0] F3_JALR = 3'd0;

  // funct7 / funct6
  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;
  localparam logic [5:0] F6_SRL  = 6'h00;
  localparam logic [5:0] F6_SRA  = 6'h10;

  // item kinds
  localparam logic KIND_EXEC    = 1'b0;
  localparam logic KIND_PRELOAD = 1'b1;

  // result word layout
  localparam int OUT_W      = 104;
  localparam int OUT_RW_BIT = 32;
  localparam int OUT_IDX_LO = 33;
  localparam int OUT_IDX_HI = 37;
  localparam int OUT_VAL_LO = 38;
  localparam int OUT_VAL_HI = 101;

endpackage

// ===== sv/rv64i_execute_core_top.sv =====
// rv64i_execute_core_top: rv64i execute core with register file and byte data memory
// pipeline: the accepted input word is registered in the execute stage, then write-back, then the result register
// a new word waits while one is in execute or write-back is stalled, set by the register file read before write-back
// reset: synchronous active low; pc and register valid bits cleared at once, so registers read as zero
// after reset the data memory is swept clear, one 8-byte row per cycle over all
// MEM_BYTES/8 rows, with in_tready low until the sweep ends
`timescale 1ns / 1ps
module rv64i_execute_core_top
  import rvx_pkg::*;
#(
  parameter int MEM_BYTES = 131072,
  parameter int REG_COUNT = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [63:0]        in_tdata,   // instruction[31:0], preload_address[48:32], preload_byte[56:49]
  input  logic               in_tuser,   // kind
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [OUT_W-1:0]   out_tdata   // next_pc, reg_written, reg_index, reg_value, branch_taken, mem_written
);

  localparam int ADDR_W = $clog2(MEM_BYTES);
  localparam int ROW_W  = ADDR_W - 3;
  localparam int ROWS   = MEM_BYTES / 8;
  localparam int RIDX_W = $clog2(REG_COUNT);

  // input word fields
  logic [31:0] in_instr;
  logic [16:0] in_paddr;
  logic [7:0]  in_pbyte;
  logic [4:0]  in_rs1, in_rs2;
  logic        in_accept;
  assign in_instr  = in_tdata[31:0];
  assign in_paddr  = in_tdata[48:32];
  assign in_pbyte  = in_tdata[56:49];
  assign in_rs1    = in_instr[19:15];
  assign in_rs2    = in_instr[24:20];
  assign in_accept = in_tvalid && in_tready;

  // stage registers
  logic              clr_act_r;
  logic [ROW_W-1:0]  clr_row_r;
  logic              y_v_r, y_kind_r;
  logic [31:0]       y_instr_r;
  logic [16:0]       y_paddr_r;
  logic [7:0]        y_pbyte_r;
  logic [63:0]       q1_r, q2_r, bd_r;
  logic              v1_r, v2_r, b1_r, b2_r;
  logic [63:0]       rf [REG_COUNT];
  logic [REG_COUNT-1:0] rf_vld_r;
  logic [31:0]       pc_r;
  logic              z_v_r, z_wr_r, z_load_r, z_taken_r, z_memw_r;
  logic [4:0]        z_rd_r;
  logic [63:0]       z_val_r;
  logic [2:0]        z_f3_r, z_lane_r;
  logic [31:0]       z_npc_r;
  logic [7:0]        mem_q [8];
  logic              out_v_r;
  logic [OUT_W-1:0]  out_data_r;

  logic z_adv;
  assign z_adv     = z_v_r && (!out_v_r || out_tready);
  assign in_tready = !clr_act_r && !y_v_r && (!z_v_r || z_adv);

  // write-back value, including load formatting
  logic [63:0] ld64, z_res, z_wval;
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      ld64[8*i +: 8] = mem_q[3'(z_lane_r + 3'(i))];
    end
    case (z_f3_r)
      F3_LB:   z_res = {{56{ld64[7]}}, ld64[7:0]};
      F3_LH:   z_res = {{48{ld64[15]}}, ld64[15:0]};
      F3_LW:   z_res = {{32{ld64[31]}}, ld64[31:0]};
      F3_LD:   z_res = ld64;
      F3_LBU:  z_res = {56'd0, ld64[7:0]};
      F3_LHU:  z_res = {48'd0, ld64[15:0]};
      F3_LWU:  z_res = {32'd0, ld64[31:0]};
      default: z_res = 64'd0;
    endcase
    if (!z_load_r) z_res = z_val_r;
    z_wval = z_wr_r ? z_res : 64'd0;
  end

  // register file: read at accept, write at end of write-back
  always_ff @(posedge clk) begin
    if (in_accept) begin
      q1_r <= rf[in_rs1[RIDX_W-1:0]];
      q2_r <= rf[in_rs2[RIDX_W-1:0]];
    end
    if (z_adv && z_wr_r) rf[z_rd_r[RIDX_W-1:0]] <= z_res;
  end

  // valid bits and same-edge bypass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r <= '0;
    end else if (z_adv && z_wr_r) begin
      rf_vld_r[z_rd_r[RIDX_W-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      v1_r      <= rf_vld_r[in_rs1[RIDX_W-1:0]];
      v2_r      <= rf_vld_r[in_rs2[RIDX_W-1:0]];
      b1_r      <= z_adv && z_wr_r && (z_rd_r == in_rs1);
      b2_r      <= z_adv && z_wr_r && (z_rd_r == in_rs2);
      bd_r      <= z_res;
      y_kind_r  <= in_tuser;
      y_instr_r <= in_instr;
      y_paddr_r <= in_paddr;
      y_pbyte_r <= in_pbyte;
    end
  end

  // execute stage decode
  logic [6:0]  opc, f7;
  logic [2:0]  f3;
  logic [5:0]  f6;
  logic [4:0]  rd, rs1, rs2;
  logic [63:0] a, b, immi, imms, immb, immj, opb;
  logic [63:0] sum, diff, addr, alu_val;
  logic        lt_s, lt_u, eq;
  logic [5:0]  shamt;
  logic [31:0] pc4;

  assign opc = y_instr_r[6:0];
  assign rd  = y_instr_r[11:7];
  assign f3  = y_instr_r[14:12];
  assign rs1 = y_instr_r[19:15];
  assign rs2 = y_instr_r[24:20];
  assign f7  = y_instr_r[31:25];
  assign f6  = y_instr_r[31:26];

  assign a = (rs1 == 5'd0) ? 64'd0 : (b1_r ? bd_r : (v1_r ? q1_r : 64'd0));
  assign b = (rs2 == 5'd0) ? 64'd0 : (b2_r ? bd_r : (v2_r ? q2_r : 64'd0));

  assign immi = {{52{y_instr_r[31]}}, y_instr_r[31:20]};
  assign imms = {{52{y_instr_r[31]}}, y_instr_r[31:25], y_instr_r[11:7]};
  assign immb = {{51{y_instr_r[31]}}, y_instr_r[31], y_instr_r[7], y_instr_r[30:25],
                 y_instr_r[11:8], 1'b0};
  assign immj = {{43{y_instr_r[31]}}, y_instr_r[31], y_instr_r[19:12], y_instr_r[20],
                 y_instr_r[30:21], 1'b0};

  // shared operand path
  assign opb   = (opc == OP_IMM) ? immi : b;
  assign sum   = a + opb;
  assign diff  = a - opb;
  assign lt_s  = $signed(a) < $signed(opb);
  assign lt_u  = a < opb;
  assign eq    = (a == opb);
  assign shamt = opb[5:0];
  assign addr  = a + ((opc == OP_STORE) ? imms : immi);
  assign pc4   = pc_r + 32'd4;

  always_comb begin
    case (f3)
      F3_ADD:  alu_val = sum;
      F3_SLL:  alu_val = a << shamt;
      F3_SLT:  alu_val = {63'd0, lt_s};
      F3_SLTU: alu_val = {63'd0, lt_u};
      F3_XOR:  alu_val = a ^ opb;
      F3_SR:   alu_val = a >> shamt;
      F3_OR:   alu_val = a | opb;
      default: alu_val = a & opb;
    endcase
  end

  // instruction effects
  logic        y_wr, y_taken, y_memw, y_load;
  logic [63:0] y_val;
  logic [31:0] y_npc;
  always_comb begin
    y_wr    = 1'b0;
    y_taken = 1'b0;
    y_memw  = 1'b0;
    y_load  = 1'b0;
    y_val   = 64'd0;
    y_npc   = pc4;
    unique case (opc)
      OP_REG: begin
        if (f7 == F7_BASE) begin
          y_wr  = 1'b1;
          y_val = alu_val;
        end else if (f7 == F7_ALT && f3 == F3_ADD) begin
          y_wr  = 1'b1;
          y_val = diff;
        end else if (f7 == F7_ALT && f3 == F3_SR) begin
          y_wr  = 1'b1;
          y_val = 64'($signed(a) >>> shamt);
        end
      end
      OP_IMM: begin
        y_wr  = 1'b1;
        y_val = alu_val;
        if (f3 == F3_SLL && f6 != F6_SRL) y_wr = 1'b0;
        if (f3 == F3_SR) begin
          if (f6 == F6_SRA) y_val = 64'($signed(a) >>> shamt);
          else if (f6 != F6_SRL) y_wr = 1'b0;
        end
      end
      OP_LOAD: begin
        y_wr   = (f3 != F3_BAD);
        y_load = y_wr;
      end
      OP_STORE: y_memw = !f3[2];
      OP_BRANCH: begin
        case (f3)
          F3_BEQ:  y_taken = eq;
          F3_BNE:  y_taken = !eq;
          F3_BLT:  y_taken = lt_s;
          F3_BGE:  y_taken = !lt_s;
          F3_BLTU: y_taken = lt_u;
          F3_BGEU: y_taken = !lt_u;
          default: y_taken = 1'b0;
        endcase
        if (y_taken) y_npc = pc_r + immb[31:0];
      end
      OP_JAL: begin
        y_wr    = 1'b1;
        y_val   = {32'd0, pc4};
        y_npc   = pc_r + immj[31:0];
        y_taken = 1'b1;
      end
      OP_JALR: begin
        if (f3 == F3_JALR) begin
          y_wr    = 1'b1;
          y_val   = {32'd0, pc4};
          y_npc   = {addr[31:1], 1'b0};
          y_taken = 1'b1;
        end
      end
      OP_LUI: begin
        y_wr  = 1'b1;
        y_val = {{32{y_instr_r[31]}}, y_instr_r[31:12], 12'd0};
      end
      default: y_wr = 1'b0;
    endcase
    if (rd == 5'd0) y_wr = 1'b0;
    if (y_kind_r == KIND_PRELOAD) begin
      y_wr    = 1'b0;
      y_load  = 1'b0;
      y_taken = 1'b0;
      y_memw  = 1'b1;
      y_npc   = pc_r;
    end
  end

  // byte lane addressing for the banked data memory
  logic [63:0]       acc_addr, acc_data, pa64;
  logic [2:0]        lane0;
  logic [ROW_W-1:0]  row0;
  logic [3:0]        nbytes;
  logic [ROW_W-1:0]  bk_row [8];
  logic [7:0]        bk_wd [8];
  logic [7:0]        bk_we;
  logic              bk_re;
  always_comb begin
    logic [2:0] off;
    pa64     = {47'd0, y_paddr_r};
    acc_addr = (y_kind_r == KIND_PRELOAD) ? pa64 : addr;
    acc_data = (y_kind_r == KIND_PRELOAD) ? {56'd0, y_pbyte_r} : b;
    nbytes   = (y_kind_r == KIND_PRELOAD) ? 4'd1 : (4'd1 << f3[1:0]);
    lane0    = acc_addr[2:0];
    row0     = acc_addr[ADDR_W-1:3];
    bk_re    = y_v_r && y_load;
    for (int l = 0; l < 8; l++) begin
      off = 3'(l) - lane0;
      if (clr_act_r) begin
        bk_row[l] = clr_row_r;
        bk_wd[l]  = 8'd0;
        bk_we[l]  = 1'b1;
      end else begin
        bk_row[l] = (3'(l) < lane0) ? row0 + 1'b1 : row0;
        bk_wd[l]  = acc_data[{off, 3'b000} +: 8];
        bk_we[l]  = y_v_r && y_memw && ({1'b0, off} < nbytes);
      end
    end
  end

  // data memory: eight byte-wide banks
  for (genvar l = 0; l < 8; l++) begin : g_lane
    logic [7:0] bank [ROWS];
    always_ff @(posedge clk) begin
      if (bk_we[l]) bank[bk_row[l]] <= bk_wd[l];
      if (bk_re) mem_q[l] <= bank[bk_row[l]];
    end
  end

  // clearing sweep after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_act_r <= 1'b1;
      clr_row_r <= '0;
    end else if (clr_act_r) begin
      clr_row_r <= clr_row_r + 1'b1;
      if (&clr_row_r) clr_act_r <= 1'b0;
    end
  end

  // pipeline control and pc
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      y_v_r   <= 1'b0;
      z_v_r   <= 1'b0;
      out_v_r <= 1'b0;
      pc_r    <= 32'd0;
    end else begin
      y_v_r <= in_accept;
      if (y_v_r) begin
        z_v_r <= 1'b1;
        pc_r  <= y_npc;
      end else if (z_adv) begin
        z_v_r <= 1'b0;
      end
      if (z_adv) out_v_r <= 1'b1;
      else if (out_tready) out_v_r <= 1'b0;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (y_v_r) begin
      z_wr_r    <= y_wr;
      z_rd_r    <= rd;
      z_val_r   <= y_val;
      z_load_r  <= y_load;
      z_f3_r    <= f3;
      z_lane_r  <= lane0;
      z_npc_r   <= y_npc;
      z_taken_r <= y_taken;
      z_memw_r  <= y_memw;
    end
    if (z_adv) begin
      out_data_r <= {z_memw_r, z_taken_r, z_wval, (z_wr_r ? z_rd_r : 5'd0), z_wr_r, z_npc_r};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== sv/rvx_checker.sv =====
// rvx_checker: port-level assertions for the rv64i execute core, with bind
`timescale 1ns / 1ps
module rvx_checker
  import rvx_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // no two words are taken back to back
  a_in_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted on consecutive cycles");

  // no register write means zero index and value
  a_no_wr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[OUT_RW_BIT] |->
      out_tdata[OUT_IDX_HI:OUT_IDX_LO] == 5'd0 && out_tdata[OUT_VAL_HI:OUT_VAL_LO] == 64'd0)
    else $error("index or value set without a register write");

  // a register write never targets x0
  a_wr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[OUT_RW_BIT] |-> out_tdata[OUT_IDX_HI:OUT_IDX_LO] != 5'd0)
    else $error("register write reported to x0");

endmodule

bind rv64i_execute_core_top rvx_checker u_rvx_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== verif/rv64i_execute_core_top_test.sv =====
// rv64i_execute_core_top_test: stream testbench for the rv64i execute core with its own predictor
`timescale 1ns / 1ps
module rv64i_execute_core_top_test
  import rvx_pkg::*;
();

  localparam int MEM_BYTES   = 131072;
  localparam int TAKEN_BIT   = 102;
  localparam int MEMW_BIT    = 103;
  localparam int RAND_ITEMS  = 400;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        reg_written;
    logic [4:0]  reg_index;
    logic [63:0] reg_value;
    logic        branch_taken;
    logic        mem_written;
  } retire_t;

  typedef struct {
    logic        kind;
    logic [31:0] instr;
    logic [16:0] addr;
    logic [7:0]  data;
    bit          typed;
    retire_t     want;
  } stim_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [63:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  // architectural state mirror
  logic [63:0] arch_regs [0:31];
  logic [31:0] arch_pc;
  logic [7:0]  arch_mem [0:MEM_BYTES-1];

  retire_t pending_retires[$];
  stim_t   dir_rows[$];
  int      n_errors = 0;
  int      n_in = 0;
  int      n_out = 0;
  int      n_cycles = 0;
  int      hold_left = 0;
  bit      hold_done = 0;
  bit      quiet = 0;

  rv64i_execute_core_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #5 clk = ~clk;

  // instruction encoders
  function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3, logic [4:0] rd, logic [6:0] op);
    return {f7, rs2, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                        logic [4:0] rd, logic [6:0] op);
    return {imm, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
  endfunction

  function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3);
    return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OP_BRANCH};
  endfunction

  function automatic logic [31:0] enc_j(logic [20:0] imm, logic [4:0] rd);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OP_JAL};
  endfunction

  function automatic logic [63:0] read_reg(logic [4:0] i);
    return (i == 5'd0) ? 64'd0 : arch_regs[i];
  endfunction

  function automatic logic [63:0] load_bytes(logic [63:0] base, int nbytes);
    logic [63:0] v;
    logic [63:0] a;
    v = '0;
    for (int i = 0; i < nbytes; i++) begin
      a = base + i;
      v[8*i +: 8] = arch_mem[a[16:0]];
    end
    return v;
  endfunction

  // advance the mirror by one word and return what the core should retire
  function automatic retire_t retire_word(logic kind, logic [31:0] ins, logic [16:0] paddr,
                                          logic [7:0] pbyte);
    retire_t r;
    logic [63:0] a, b, immi, imm, val, ad;
    logic [31:0] npc;
    logic [6:0] opc, f7;
    logic [5:0] f6, sh;
    logic [4:0] rd;
    logic [2:0] f3;
    logic wr, taken, memw;
    r = '0;
    if (kind == KIND_PRELOAD) begin
      arch_mem[paddr] = pbyte;
      r.next_pc = arch_pc;
      r.mem_written = 1'b1;
      return r;
    end
    opc = ins[6:0]; rd = ins[11:7]; f3 = ins[14:12]; f7 = ins[31:25]; f6 = ins[31:26];
    sh = ins[25:20];
    a = read_reg(ins[19:15]);
    b = read_reg(ins[24:20]);
    immi = {{52{ins[31]}}, ins[31:20]};
    npc = arch_pc + 32'd4;
    wr = 0; taken = 0; memw = 0; val = '0;
    case (opc)
      OP_REG: begin
        wr = 1;
        if (f7 == F7_BASE) begin
          case (f3)
            F3_ADD:  val = a + b;
            F3_SLL:  val = a << b[5:0];
            F3_SLT:  val = ($signed(a) < $signed(b)) ? 64'd1 : 64'd0;
            F3_SLTU: val = (a < b) ? 64'd1 : 64'd0;
            F3_XOR:  val = a ^ b;
            F3_SR:   val = a >> b[5:0];
            F3_OR:   val = a | b;
            default: val = a & b;
          endcase
        end else if (f7 == F7_ALT && f3 == F3_ADD) val = a - b;
        else if (f7 == F7_ALT && f3 == F3_SR) val = $signed(a) >>> b[5:0];
        else wr = 0;
      end
      OP_IMM: begin
        wr = 1;
        case (f3)
          F3_ADD:  val = a + immi;
          F3_SLT:  val = ($signed(a) < $signed(immi)) ? 64'd1 : 64'd0;
          F3_SLTU: val = (a < immi) ? 64'd1 : 64'd0;
          F3_XOR:  val = a ^ immi;
          F3_OR:   val = a | immi;
          F3_AND:  val = a & immi;
          F3_SLL:  if (f6 == F6_SRL) val = a << sh; else wr = 0;
          default: begin
            if (f6 == F6_SRL) val = a >> sh;
            else if (f6 == F6_SRA) val = $signed(a) >>> sh;
            else wr = 0;
          end
        endcase
      end
      OP_LOAD: begin
        ad = a + immi;
        wr = 1;
        case (f3)
          F3_LB:  begin val = load_bytes(ad, 1); val = {{56{val[7]}}, val[7:0]}; end
          F3_LH:  begin val = load_bytes(ad, 2); val = {{48{val[15]}}, val[15:0]}; end
          F3_LW:  begin val = load_bytes(ad, 4); val = {{32{val[31]}}, val[31:0]}; end
          F3_LD:  val = load_bytes(ad, 8);
          F3_LBU: val = load_bytes(ad, 1);
          F3_LHU: val = load_bytes(ad, 2);
          F3_LWU: val = load_bytes(ad, 4);
          default: wr = 0;
        endcase
      end
      OP_STORE: begin
        imm = {{52{ins[31]}}, ins[31:25], ins[11:7]};
        if (f3 <= 3'd3) begin
          for (int i = 0; i < (1 << f3); i++) begin
            ad = a + imm + i;
            arch_mem[ad[16:0]] = b[8*i +: 8];
          end
          memw = 1;
        end
      end
      OP_BRANCH: begin
        imm = {{51{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
        case (f3)
          F3_BEQ:  taken = (a == b);
          F3_BNE:  taken = (a != b);
          F3_BLT:  taken = ($signed(a) < $signed(b));
          F3_BGE:  taken = !($signed(a) < $signed(b));
          F3_BLTU: taken = (a < b);
          F3_BGEU: taken = (a >= b);
          default: taken = 0;
        endcase
        if (taken) npc = arch_pc + imm[31:0];
      end
      OP_JAL: begin
        imm = {{43{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
        wr = 1;
        val = {32'd0, arch_pc + 32'd4};
        npc = arch_pc + imm[31:0];
        taken = 1;
      end
      OP_JALR: begin
        if (f3 == F3_JALR) begin
          wr = 1;
          val = {32'd0, arch_pc + 32'd4};
          ad = a + immi;
          npc = {ad[31:1], 1'b0};
          taken = 1;
        end
      end
      OP_LUI: begin
        wr = 1;
        val = {{32{ins[31]}}, ins[31:12], 12'd0};
      end
      default: ;
    endcase
    if (rd == 5'd0) wr = 0;
    if (wr) arch_regs[rd] = val;
    arch_pc = npc;
    r.next_pc = npc;
    r.reg_written = wr;
    r.reg_index = wr ? rd : 5'd0;
    r.reg_value = wr ? val : 64'd0;
    r.branch_taken = taken;
    r.mem_written = memw;
    return r;
  endfunction

  function automatic logic [4:0] rnd_reg();
    return 5'($urandom_range(0, 31));
  endfunction

  // random instruction, mostly well formed with random operands
  function automatic logic [31:0] rand_instr();
    logic [6:0] f7;
    logic [11:0] imm;
    logic [2:0] f3;
    logic [4:0] base;
    f3 = 3'($urandom_range(0, 7));
    base = ($urandom_range(0, 3) == 0) ? rnd_reg() : 5'd0;
    case ($urandom_range(0, 9))
      0, 1: begin
        case ($urandom_range(0, 3))
          0, 1: f7 = F7_BASE;
          2: f7 = F7_ALT;
          default: f7 = 7'($urandom);
        endcase
        return enc_r(f7, rnd_reg(), rnd_reg(), f3, rnd_reg(), OP_REG);
      end
      2: begin
        imm = 12'($urandom);
        if (f3 == F3_SLL || f3 == F3_SR)
          case ($urandom_range(0, 3))
            0, 1: imm[11:6] = F6_SRL;
            2: imm[11:6] = F6_SRA;
            default: ;
          endcase
        return enc_i(imm, rnd_reg(), f3, rnd_reg(), OP_IMM);
      end
      3: return enc_i(12'($urandom), base, f3, rnd_reg(), OP_LOAD);
      4: return enc_s(12'($urandom), rnd_reg(), base, f3);
      5: return enc_b(13'($urandom), rnd_reg(), rnd_reg(), f3);
      6: return enc_j(21'($urandom), rnd_reg());
      7: return enc_i(12'($urandom), rnd_reg(), ($urandom_range(0, 4) == 0) ? f3 : F3_JALR,
                      rnd_reg(), OP_JALR);
      8: return {20'($urandom), rnd_reg(), OP_LUI};
      default: return 32'($urandom);
    endcase
  endfunction

  function automatic void add_row(logic [31:0] ins);
    stim_t s;
    s = '{kind: KIND_EXEC, instr: ins, addr: '0, data: '0, typed: 0, want: '0};
    dir_rows.push_back(s);
  endfunction

  function automatic void add_typed(logic kind, logic [31:0] ins, logic [16:0] ad,
                                    logic [7:0] d, retire_t w);
    stim_t s;
    s = '{kind: kind, instr: ins, addr: ad, data: d, typed: 1, want: w};
    dir_rows.push_back(s);
  endfunction

  // send one word; expectation is recorded at the accepting edge
  task automatic send_word(logic kind, logic [31:0] ins, logic [16:0] ad, logic [7:0] d,
                           bit typed, retire_t w);
    retire_t p;
    while (!quiet && $urandom_range(0, 99) < 30) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {7'd0, d, ad, ins};
    do @(posedge clk); while (!in_tready);
    p = retire_word(kind, ins, ad, d);
    pending_retires.push_back(typed ? w : p);
    n_in++;
  endtask

  // result side: check each retired word, random backpressure, one long hold-off
  always @(posedge clk) begin
    retire_t got, exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      got.next_pc = out_tdata[31:0];
      got.reg_written = out_tdata[OUT_RW_BIT];
      got.reg_index = out_tdata[OUT_IDX_HI:OUT_IDX_LO];
      got.reg_value = out_tdata[OUT_VAL_HI:OUT_VAL_LO];
      got.branch_taken = out_tdata[TAKEN_BIT];
      got.mem_written = out_tdata[MEMW_BIT];
      n_out++;
      if (pending_retires.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, out_tdata);
        n_errors++;
      end else begin
        exp_r = pending_retires.pop_front();
        if (got.next_pc !== exp_r.next_pc) begin
          $display("%0t: next_pc exp %h got %h", $time, exp_r.next_pc, got.next_pc);
          n_errors++;
        end
        if (got.reg_written !== exp_r.reg_written) begin
          $display("%0t: reg_written exp %b got %b", $time, exp_r.reg_written, got.reg_written);
          n_errors++;
        end
        if (got.reg_index !== exp_r.reg_index) begin
          $display("%0t: reg_index exp %0d got %0d", $time, exp_r.reg_index, got.reg_index);
          n_errors++;
        end
        if (got.reg_value !== exp_r.reg_value) begin
          $display("%0t: reg_value exp %h got %h", $time, exp_r.reg_value, got.reg_value);
          n_errors++;
        end
        if (got.branch_taken !== exp_r.branch_taken) begin
          $display("%0t: branch_taken exp %b got %b", $time, exp_r.branch_taken,
                   got.branch_taken);
          n_errors++;
        end
        if (got.mem_written !== exp_r.mem_written) begin
          $display("%0t: mem_written exp %b got %b", $time, exp_r.mem_written, got.mem_written);
          n_errors++;
        end
      end
    end
    if (!hold_done && n_out >= 120) begin
      hold_done <= 1;
      hold_left <= 80;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 30);
    end
  end

  // watchdog, includes the memory sweep after reset
  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d words still expected", $time, pending_retires.size());
      $display("** rv64i_execute_core_top: FAILED **");
      $finish;
    end
  end

  initial begin
    retire_t w;
    int n_wait;
    for (int i = 0; i < 32; i++) arch_regs[i] = '0;
    for (int i = 0; i < MEM_BYTES; i++) arch_mem[i] = '0;
    arch_pc = '0;

    // directed words: extremes and every major opcode
    w = '{next_pc: 32'd4, reg_written: 1, reg_index: 5'd1, reg_value: 64'hFFFF_FFFF_FFFF_F000,
          branch_taken: 0, mem_written: 0};
    add_typed(KIND_EXEC, {20'hFFFFF, 5'd1, OP_LUI}, '0, '0, w);
    w = '{next_pc: 32'd8, reg_written: 1, reg_index: 5'd2, reg_value: '1,
          branch_taken: 0, mem_written: 0};
    add_typed(KIND_EXEC, enc_i(12'hFFF, 5'd0, F3_ADD, 5'd2, OP_IMM), '0, '0, w);
    w = '{next_pc: 32'd12, reg_written: 1, reg_index: 5'd3, reg_value: 64'd2047,
          branch_taken: 0, mem_written: 0};
    add_typed(KIND_EXEC, enc_i(12'h7FF, 5'd0, F3_ADD, 5'd3, OP_IMM), '0, '0, w);
    w = '{next_pc: 32'd12, reg_written: 0, reg_index: 5'd0, reg_value: '0,
          branch_taken: 0, mem_written: 1};
    add_typed(KIND_PRELOAD, '0, 17'h1FFFF, 8'h80, w);
    add_row(enc_r(F7_BASE, 5'd3, 5'd2, F3_ADD, 5'd4, OP_REG));
    add_row(enc_r(F7_ALT, 5'd2, 5'd3, F3_ADD, 5'd5, OP_REG));
    add_row(enc_r(F7_BASE, 5'd3, 5'd2, F3_SLL, 5'd6, OP_REG));
    add_row(enc_r(F7_BASE, 5'd3, 5'd2, F3_SLT, 5'd7, OP_REG));
    add_row(enc_r(F7_BASE, 5'd3, 5'd2, F3_SLTU, 5'd8, OP_REG));
    add_row(enc_r(F7_BASE, 5'd3, 5'd1, F3_XOR, 5'd9, OP_REG));
    add_row(enc_r(F7_BASE, 5'd3, 5'd2, F3_SR, 5'd10, OP_REG));
    add_row(enc_r(F7_ALT, 5'd3, 5'd1, F3_SR, 5'd11, OP_REG));
    add_row(enc_r(F7_BASE, 5'd3, 5'd1, F3_OR, 5'd12, OP_REG));
    add_row(enc_r(F7_BASE, 5'd2, 5'd1, F3_AND, 5'd13, OP_REG));
    add_row(enc_r(7'h01, 5'd2, 5'd1, F3_ADD, 5'd14, OP_REG));
    add_row(enc_i({F6_SRL, 6'd63}, 5'd2, F3_SLL, 5'd15, OP_IMM));
    add_row(enc_i({F6_SRA, 6'd4}, 5'd1, F3_SR, 5'd16, OP_IMM));
    add_row(enc_i({F6_SRL, 6'd40}, 5'd1, F3_SR, 5'd17, OP_IMM));
    add_row(enc_i({6'h3F, 6'd1}, 5'd1, F3_SR, 5'd18, OP_IMM));
    add_row(enc_i(12'hFFF, 5'd2, F3_SLT, 5'd19, OP_IMM));
    add_row(enc_i(12'hFFF, 5'd3, F3_SLTU, 5'd20, OP_IMM));
    add_row(enc_i(12'h800, 5'd3, F3_XOR, 5'd21, OP_IMM));
    // wrapping double store and loads around the top of memory
    add_row(enc_s(12'hFFE, 5'd1, 5'd0, 3'd3));
    add_row(enc_i(12'hFFE, 5'd0, F3_LD, 5'd22, OP_LOAD));
    add_row(enc_i(12'hFFF, 5'd0, F3_LB, 5'd23, OP_LOAD));
    add_row(enc_i(12'hFFF, 5'd0, F3_LHU, 5'd24, OP_LOAD));
    add_row(enc_i(12'hFFF, 5'd0, F3_BAD, 5'd25, OP_LOAD));
    add_row(enc_s(12'h010, 5'd2, 5'd0, 3'd4));
    add_row(enc_b(13'h1FF8, 5'd3, 5'd2, F3_BLT));
    add_row(enc_b(13'h0010, 5'd3, 5'd2, F3_BLTU));
    add_row(enc_b(13'h0010, 5'd3, 5'd2, 3'd2));
    add_row(enc_j(21'h1FFFFC, 5'd26));
    add_row(enc_i(12'h001, 5'd1, F3_JALR, 5'd1, OP_JALR));
    add_row({25'h0, 7'h17});
    add_row(enc_i(12'h123, 5'd3, F3_ADD, 5'd0, OP_IMM));

    in_tvalid <= 1'b0;
    rst_n <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      send_word(dir_rows[i].kind, dir_rows[i].instr, dir_rows[i].addr, dir_rows[i].data,
                dir_rows[i].typed, dir_rows[i].want);

    // random words, with a stretch of no idling in the middle
    for (int i = 0; i < RAND_ITEMS; i++) begin
      quiet = (i >= 200 && i < 280);
      if ($urandom_range(0, 99) < 15)
        send_word(KIND_PRELOAD, 32'($urandom), 17'($urandom), 8'($urandom), 0, '0);
      else
        send_word(KIND_EXEC, rand_instr(), 17'($urandom), 8'($urandom), 0, '0);
    end
    quiet = 0;
    in_tvalid <= 1'b0;

    n_wait = 0;
    while (pending_retires.size() != 0 && n_wait < 10000) begin
      @(posedge clk);
      n_wait++;
    end
    repeat (10) @(posedge clk);
    if (pending_retires.size() != 0) begin
      $display("%0d expected words never arrived", pending_retires.size());
      n_errors++;
    end
    $display("sent %0d words (directed opcode sweep plus random mix with preloads),", n_in);
    $display("checked %0d retired words, %0d mismatches", n_out, n_errors);
    if (n_errors == 0) begin
      $display("** rv64i_execute_core_top: PASSED **");
    end else begin
      $display("** rv64i_execute_core_top: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/rvx_pkg.sv
sv/rv64i_execute_core_top.sv
sv/rvx_checker.sv
verif/rv64i_execute_core_top_test.sv
